### rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg: shared types and constants for the flow counter table
// Beat structs, status codes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int TableEntries = 64;
  localparam int IdxW = $clog2(TableEntries);

  localparam logic [1:0] StatusHit  = 2'd0;
  localparam logic [1:0] StatusNew  = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  typedef struct packed {
    logic [31:0] first_address;
    logic [31:0] second_address;
    logic [15:0] first_port;
    logic [15:0] second_port;
    logic [7:0]  protocol_number;
    logic [15:0] packet_length;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  entry_index;
    logic [63:0] packet_total;
    logic [63:0] byte_total;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic read;
    logic write;
    logic emit;
  } fct_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic has_free;
  } fct_stat_t;

endpackage

### rtl/flow_counter_table.sv
// ----------------------------------------------------------------------------
// flow_counter_table: per-flow packet and byte counters over an exact table
// Direction-free five-tuple lookup with hit update, new-entry allocation or a full status.
// ----------------------------------------------------------------------------
// Usage: drive in_data and raise start while busy is low; the beat is taken
// at that edge and busy rises on the next cycle. The table is scanned one
// entry per cycle through the key memories; each packet passes through a
// load step, the scan including the read pipeline drain, a counter read and
// a write back. The result appears on out_data with done high for one
// cycle, in the cycle after the write back; the receiver cannot stall and
// must take it then. busy drops in the same cycle as done, so the next
// start may be taken then.
// Reset clears all valid bits at once; no clearing pass is needed and
// counters or keys of unwritten entries are never used.
// ----------------------------------------------------------------------------
module flow_counter_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  fct_pkg::in_beat_t  in_data,
  output logic               done,
  output fct_pkg::out_beat_t out_data
);
  import fct_pkg::*;

  fct_cmd_t  cmd;
  fct_stat_t stat;

  fct_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  fct_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .in_beat (in_data),
    .done    (done),
    .out_beat(out_data)
  );

endmodule

### rtl/fct_ctrl.sv
// ----------------------------------------------------------------------------
// fct_ctrl: sequencer for the flow counter table
// Steps load, scan, counter read, write back and result for each packet.
// ----------------------------------------------------------------------------
module fct_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  fct_pkg::fct_stat_t stat,
  output fct_pkg::fct_cmd_t  cmd
);
  import fct_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StRead  = 2'd2;
  localparam logic [1:0] StWrite = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      StIdle: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = StScan;
        end
      end
      StScan: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_next = StRead;
      end
      StRead: begin
        cmd.read = 1'b1;
        state_next = StWrite;
      end
      StWrite: begin
        cmd.write = 1'b1;
        cmd.emit = 1'b1;
        state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end

  assign busy = (state != StIdle);

  always_ff @(posedge clk) begin
    if (rst) state <= StIdle;
    else state <= state_next;
  end

  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !cmd.emit) else $error("emit repeated");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> busy) else $error("load without busy");
  a_read_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.read |-> $past(cmd.scan)) else $error("read without scan");

endmodule

### rtl/fct_dp.sv
// ----------------------------------------------------------------------------
// fct_dp: key build, table scan and counter update for the flow table
// Scans one entry per cycle; counters sit in a single-port memory.
// ----------------------------------------------------------------------------
module fct_dp (
  input  logic                clk,
  input  logic                rst,
  input  fct_pkg::fct_cmd_t   cmd,
  output fct_pkg::fct_stat_t  stat,
  input  fct_pkg::in_beat_t   in_beat,
  output logic                done,
  output fct_pkg::out_beat_t  out_beat
);
  import fct_pkg::*;

  logic [TableEntries-1:0] valid;
  logic [63:0]  key_addr_mem [TableEntries];
  logic [39:0]  key_pp_mem   [TableEntries];
  logic [127:0] cnt_mem      [TableEntries];

  logic [63:0]  kaddr;
  logic [39:0]  kpp;
  logic [15:0]  len;
  logic [IdxW:0] scan_idx;
  logic [IdxW-1:0] hit_idx;
  logic [IdxW-1:0] free_idx;
  logic hit;
  logic has_free;
  logic [63:0] rd_addr;
  logic [39:0] rd_pp;
  logic rd_valid;
  logic [IdxW-1:0] rd_idx;
  logic [127:0] cnt_rd;
  logic [IdxW-1:0] tgt;
  logic [63:0] pkt_new;
  logic [63:0] byt_new;
  logic [31:0] lo_a, hi_a;
  logic [15:0] lo_p, hi_p;

  always_comb begin
    lo_a = (in_beat.first_address < in_beat.second_address) ?
           in_beat.first_address : in_beat.second_address;
    hi_a = (in_beat.first_address < in_beat.second_address) ?
           in_beat.second_address : in_beat.first_address;
    lo_p = (in_beat.first_port < in_beat.second_port) ?
           in_beat.first_port : in_beat.second_port;
    hi_p = (in_beat.first_port < in_beat.second_port) ?
           in_beat.second_port : in_beat.first_port;
  end

  assign stat.scan_done = scan_idx[IdxW];
  assign stat.hit = hit;
  assign stat.has_free = has_free;
  assign tgt = hit ? hit_idx : free_idx;

  // Key memories read one entry per cycle; compare on the registered word.
  always_ff @(posedge clk) begin
    rd_addr <= key_addr_mem[scan_idx[IdxW-1:0]];
    rd_pp   <= key_pp_mem[scan_idx[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
      hit <= 1'b0;
      has_free <= 1'b0;
    end else if (cmd.load) begin
      kaddr <= {lo_a, hi_a};
      kpp <= {lo_p, hi_p, in_beat.protocol_number};
      len <= in_beat.packet_length;
      scan_idx <= '0;
      rd_valid <= 1'b0;
      hit <= 1'b0;
      has_free <= 1'b0;
    end else if (cmd.scan) begin
      if (!scan_idx[IdxW]) scan_idx <= scan_idx + (IdxW+1)'(1);
      rd_valid <= !scan_idx[IdxW];
      rd_idx <= scan_idx[IdxW-1:0];
      if (rd_valid) begin
        if (valid[rd_idx]) begin
          if (!hit && rd_addr == kaddr && rd_pp == kpp) begin
            hit <= 1'b1;
            hit_idx <= rd_idx;
          end
        end else if (!has_free) begin
          has_free <= 1'b1;
          free_idx <= rd_idx;
        end
      end
    end
  end

  // Drain the last compare before leaving the scan.
  logic last_pending;
  assign last_pending = rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.read) cnt_rd <= cnt_mem[tgt];
  end

  assign pkt_new = hit ? cnt_rd[127:64] + 64'd1 : 64'd1;
  assign byt_new = (hit ? cnt_rd[63:0] : 64'd0) + {48'd0, len};

  always_ff @(posedge clk) begin
    if (cmd.write && (hit || has_free)) begin
      cnt_mem[tgt] <= {pkt_new, byt_new};
      if (!hit) begin
        key_addr_mem[tgt] <= kaddr;
        key_pp_mem[tgt] <= kpp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else if (cmd.write && !hit && has_free) valid[tgt] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.emit;
    if (cmd.emit) begin
      if (hit) begin
        out_beat <= {StatusHit, 6'(tgt), pkt_new, byt_new};
      end else if (has_free) begin
        out_beat <= {StatusNew, 6'(tgt), pkt_new, byt_new};
      end else begin
        out_beat <= {StatusFull, 6'd0, 64'd0, 64'd0};
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> scan_idx <= (IdxW+1)'(TableEntries)) else $error("scan overrun");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.emit)) else $error("stray done");
  a_no_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.read |-> !last_pending) else $error("compare lost");

endmodule

### tb/flow_checker.sv
// ----------------------------------------------------------------------------
// flow_checker: scoreboard for the flow counter table
// Watches accepted packet beats, predicts status, entry index and counter
// totals from a private copy of the table, and compares every result beat.
// ----------------------------------------------------------------------------
module flow_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  fct_pkg::in_beat_t  in_data,
  input  logic               done,
  input  fct_pkg::out_beat_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import fct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        flow_used [TableEntries];
  logic [63:0] flow_addr [TableEntries];
  logic [39:0] flow_ports [TableEntries];
  logic [63:0] flow_pkts [TableEntries];
  logic [63:0] flow_bytes [TableEntries];
  out_beat_t   expected_beats[$];

  assign pending = expected_beats.size();

  function automatic out_beat_t account_packet(in_beat_t pkt);
    logic [31:0] lo_a, hi_a;
    logic [15:0] lo_p, hi_p;
    logic [63:0] kaddr;
    logic [39:0] kport;
    int hit_idx, free_idx;
    out_beat_t r;
    lo_a = (pkt.first_address < pkt.second_address) ? pkt.first_address : pkt.second_address;
    hi_a = (pkt.first_address < pkt.second_address) ? pkt.second_address : pkt.first_address;
    lo_p = (pkt.first_port < pkt.second_port) ? pkt.first_port : pkt.second_port;
    hi_p = (pkt.first_port < pkt.second_port) ? pkt.second_port : pkt.first_port;
    kaddr = {lo_a, hi_a};
    kport = {lo_p, hi_p, pkt.protocol_number};
    hit_idx = -1;
    free_idx = -1;
    for (int i = 0; i < TableEntries; i++) begin
      if (flow_used[i]) begin
        if (hit_idx < 0 && flow_addr[i] == kaddr && flow_ports[i] == kport) hit_idx = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    r = '0;
    if (hit_idx >= 0) begin
      flow_pkts[hit_idx] += 64'd1;
      flow_bytes[hit_idx] += {48'd0, pkt.packet_length};
      r.status = StatusHit;
      r.entry_index = hit_idx[5:0];
      r.packet_total = flow_pkts[hit_idx];
      r.byte_total = flow_bytes[hit_idx];
    end else if (free_idx >= 0) begin
      flow_used[free_idx] = 1'b1;
      flow_addr[free_idx] = kaddr;
      flow_ports[free_idx] = kport;
      flow_pkts[free_idx] = 64'd1;
      flow_bytes[free_idx] = {48'd0, pkt.packet_length};
      r.status = StatusNew;
      r.entry_index = free_idx[5:0];
      r.packet_total = 64'd1;
      r.byte_total = flow_bytes[free_idx];
    end else begin
      r.status = StatusFull;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t exp_beat;
    int errs;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < TableEntries; i++) flow_used[i] = 1'b0;
      expected_beats.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat");
          errs++;
        end else begin
          exp_beat = expected_beats.pop_front();
          if (out_data.status !== exp_beat.status) begin
            $error("status: expected %0d actual %0d", exp_beat.status, out_data.status);
            errs++;
          end
          if (out_data.entry_index !== exp_beat.entry_index) begin
            $error("entry_index: expected %0d actual %0d",
                   exp_beat.entry_index, out_data.entry_index);
            errs++;
          end
          if (out_data.packet_total !== exp_beat.packet_total) begin
            $error("packet_total: expected %0h actual %0h",
                   exp_beat.packet_total, out_data.packet_total);
            errs++;
          end
          if (out_data.byte_total !== exp_beat.byte_total) begin
            $error("byte_total: expected %0h actual %0h",
                   exp_beat.byte_total, out_data.byte_total);
            errs++;
          end
        end
      end
      if (start && !busy) expected_beats.push_back(account_packet(in_data));
      fail_count <= fail_count + errs;
    end
  end
endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the flow counter table
// Sends directed packets (key extremes, reversed direction, equal fields,
// large lengths, table fill and table full) then random packets drawn from a
// small flow pool so that hits dominate; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_top;
  import fct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  logic      done;
  in_beat_t  in_data = '0;
  out_beat_t out_data;
  int        fail_count;
  int        pending;
  in_beat_t  flow_pool[$];
  logic      quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  flow_counter_table u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_data(in_data), .done(done), .out_data(out_data)
  );

  flow_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_data(in_data),
    .done(done), .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  function automatic in_beat_t random_packet();
    in_beat_t p;
    p.first_address = $urandom;
    p.second_address = $urandom;
    p.first_port = 16'($urandom_range(0, 65535));
    p.second_port = 16'($urandom_range(0, 65535));
    p.protocol_number = 8'($urandom_range(0, 255));
    p.packet_length = 16'($urandom_range(0, 65535));
    return p;
  endfunction

  // hold the beat until taken, then at random drop start and idle for a gap
  task automatic send_packet(in_beat_t p);
    int gap;
    start <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    in_beat_t p;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    p = '0;
    send_packet(p);
    send_packet(p);
    p = '1;
    send_packet(p);
    p.packet_length = 16'hFFFF;
    send_packet(p);
    p = {32'h0A000001, 32'hC0A80001, 16'd80, 16'd443, 8'd6, 16'd1500};
    send_packet(p);
    p = {32'hC0A80001, 32'h0A000001, 16'd443, 16'd80, 8'd6, 16'd40};
    send_packet(p);
    p = {32'hC0A80001, 32'h0A000001, 16'd80, 16'd443, 8'd6, 16'd40};
    send_packet(p);
    p = {32'h12345678, 32'h12345678, 16'd7, 16'd7, 8'd17, 16'd1};
    send_packet(p);
    send_packet(p);
    p.protocol_number = 8'd18;
    send_packet(p);
    p = {32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 16'h5555, 8'hAA, 16'h5555};
    send_packet(p);
    p = {32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'hAAAA, 8'h55, 16'hAAAA};
    send_packet(p);
    // fill all but one of the remaining entries, keeping a pool for later hits
    for (int i = 0; i < 56; i++) begin
      p = random_packet();
      flow_pool.push_back(p);
      send_packet(p);
    end
    for (int i = 0; i < 6; i++) send_packet(random_packet());
    for (int i = 0; i < 800; i++) begin
      if (i >= 700) quiet = 1'b1;
      if ($urandom_range(0, 9) < 8) begin
        p = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
        if ($urandom_range(0, 1)) begin
          p = {p.second_address, p.first_address, p.second_port, p.first_port,
               p.protocol_number, p.packet_length};
        end
        p.packet_length = 16'($urandom_range(0, 65535));
      end else begin
        p = random_packet();
      end
      send_packet(p);
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
